[hdl/sal_pkg.sv]
// shared constants for the shifting array list: commands, status codes, field widths
`timescale 1ns / 1ps

package sal_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int IDX_W  = 6;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_ELEMENT = 3'd1;
    localparam logic [ST_W-1:0] ST_MATCH   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOMATCH = 3'd3;
    localparam logic [ST_W-1:0] ST_BADPOS  = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd5;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd6;

endpackage

[hdl/sal_if.sv]
// command and result channel interfaces for the shifting array list
`timescale 1ns / 1ps

interface sal_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [sal_pkg::OP_W-1:0]      operation;
    logic [sal_pkg::POS_W-1:0]     position;
    logic signed [sal_pkg::VAL_W-1:0] item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input item_value,
                    output ready);
endinterface

interface sal_res_if;
    logic                          valid;
    logic                          ready;
    logic [sal_pkg::ST_W-1:0]      status;
    logic [sal_pkg::IDX_W-1:0]     entry_index;
    logic signed [sal_pkg::VAL_W-1:0] entry_value;
    logic                          last;

    modport source (output valid, output status, output entry_index, output entry_value,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_index, input entry_value,
                    input last, output ready);
endinterface

[hdl/shifting_array_list.sv]
// Ordered list of up to DEPTH signed values in one single-port-read memory.
// Clear, append and error results go from decode to the result state, then out.
// Read all emits each entry in turn; search reads and compares each stored entry.
// Insert and delete shift entries with one memory read and one write per step.
// One command at a time; the next command is taken once the last result is registered.
// Reset clears the count and control; the memory is not cleared and needs no pass.
`timescale 1ns / 1ps

module shifting_array_list #(
    parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sal_cmd_if.sink   i_cmd,
    sal_res_if.source o_res
);
    import sal_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DECODE  = 11'b000_0000_0010,
        S_FIN     = 11'b000_0000_0100,
        S_RA_RD   = 11'b000_0000_1000,
        S_RA_EMIT = 11'b000_0001_0000,
        S_INS_RD  = 11'b000_0010_0000,
        S_INS_WR  = 11'b000_0100_0000,
        S_DEL_RD  = 11'b000_1000_0000,
        S_DEL_WR  = 11'b001_0000_0000,
        S_SR_RD   = 11'b010_0000_0000,
        S_SR_CMP  = 11'b100_0000_0000
    } t_state;

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_hit, n_hit;
    logic [OP_W-1:0]  r_op;
    logic [POS_W-1:0] r_pos;
    logic signed [VAL_W-1:0] r_val;
    logic [ST_W-1:0]  r_fin_status, n_fin_status;
    logic [IDX_W-1:0] r_fin_idx, n_fin_idx;
    logic signed [VAL_W-1:0] r_fin_val, n_fin_val;

    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [IDX_W-1:0] r_out_idx;
    logic signed [VAL_W-1:0] r_out_val;
    logic             r_out_last;

    logic             out_free;
    logic             emit;
    logic [ST_W-1:0]  emit_status;
    logic [IDX_W-1:0] emit_idx;
    logic signed [VAL_W-1:0] emit_val;
    logic             emit_last;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic [CW-1:0]    idx_inc, idx_dec;
    logic             full;
    logic             cmd_xfer;

    assign out_free = !r_out_valid || o_res.ready;
    assign cmd_xfer = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign idx_inc  = r_idx + CW'(1);
    assign idx_dec  = r_idx - CW'(1);
    assign full     = (r_count == CW'(DEPTH));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_fin_status = r_fin_status;
        n_fin_idx    = r_fin_idx;
        n_fin_val    = r_fin_val;
        emit         = 1'b0;
        emit_status  = ST_DONE;
        emit_idx     = '0;
        emit_val     = '0;
        emit_last    = 1'b1;
        rd_en        = 1'b0;
        rd_addr      = r_idx[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_idx[AW-1:0];
        wr_data      = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_xfer) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_fin_status = ST_DONE;
                n_fin_idx    = '0;
                n_fin_val    = '0;
                n_state      = S_FIN;
                case (r_op)
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    OP_APPEND: begin
                        if (full) begin
                            n_fin_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_data = r_val;
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_READ: begin
                        if (r_count != '0) begin
                            n_idx   = '0;
                            n_state = S_RA_RD;
                        end
                    end
                    OP_INSERT: begin
                        if (r_pos > POS_W'(r_count)) begin
                            n_fin_status = ST_BADPOS;
                        end else if (full) begin
                            n_fin_status = ST_FULL;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_INS_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (r_count == '0) begin
                            n_fin_status = ST_EMPTY;
                        end else if (r_pos >= POS_W'(r_count)) begin
                            n_fin_status = ST_BADPOS;
                        end else begin
                            n_idx   = CW'(r_pos);
                            n_state = S_DEL_RD;
                        end
                    end
                    OP_SEARCH: begin
                        n_idx   = '0;
                        n_hit   = 1'b0;
                        n_state = S_SR_RD;
                    end
                    default: begin
                        n_fin_status = ST_DONE;
                    end
                endcase
            end
            S_FIN: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = r_fin_status;
                    emit_idx    = r_fin_idx;
                    emit_val    = r_fin_val;
                    n_state     = S_IDLE;
                end
            end
            S_RA_RD: begin
                rd_en   = 1'b1;
                n_state = S_RA_EMIT;
            end
            S_RA_EMIT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = ST_ELEMENT;
                    emit_idx    = IDX_W'(r_idx);
                    emit_val    = r_rd_data;
                    emit_last   = (idx_inc == r_count);
                    n_idx       = idx_inc;
                    n_state     = (idx_inc == r_count) ? S_IDLE : S_RA_RD;
                end
            end
            // walk down from the count, moving each entry up by one
            S_INS_RD: begin
                if (r_idx == CW'(r_pos)) begin
                    wr_en        = 1'b1;
                    wr_data      = r_val;
                    n_count      = r_count + CW'(1);
                    n_fin_status = ST_DONE;
                    n_state      = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[AW-1:0];
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_dec;
                n_state = S_INS_RD;
            end
            // walk up from the position, moving each entry down by one
            S_DEL_RD: begin
                if (idx_inc == r_count) begin
                    n_count      = r_count - CW'(1);
                    n_fin_status = ST_DONE;
                    n_state      = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_inc;
                n_state = S_DEL_RD;
            end
            S_SR_RD: begin
                if (r_idx == r_count) begin
                    // pending match goes out last; without one report no match
                    n_fin_status = r_hit ? ST_MATCH : ST_NOMATCH;
                    if (!r_hit) begin
                        n_fin_idx = '0;
                        n_fin_val = '0;
                    end
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SR_CMP;
                end
            end
            S_SR_CMP: begin
                if (r_rd_data == r_val) begin
                    if (!r_hit || out_free) begin
                        if (r_hit) begin
                            emit        = 1'b1;
                            emit_status = ST_MATCH;
                            emit_idx    = r_fin_idx;
                            emit_val    = r_fin_val;
                            emit_last   = 1'b0;
                        end
                        n_fin_idx = IDX_W'(r_idx);
                        n_fin_val = r_rd_data;
                        n_hit     = 1'b1;
                        n_idx     = idx_inc;
                        n_state   = S_SR_RD;
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SR_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // reads and writes of the list memory never fall in the same cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_hit   <= n_hit;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_op  <= i_cmd.operation;
            r_pos <= i_cmd.position;
            r_val <= i_cmd.item_value;
        end
        r_fin_status <= n_fin_status;
        r_fin_idx    <= n_fin_idx;
        r_fin_val    <= n_fin_val;
        if (emit) begin
            r_out_status <= emit_status;
            r_out_idx    <= emit_idx;
            r_out_val    <= emit_val;
            r_out_last   <= emit_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.entry_index = r_out_idx;
    assign o_res.entry_value = r_out_val;
    assign o_res.last        = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above depth");

    a_cmd_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_DECODE))
        else $error("command transfer not followed by decode");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RA_RD || r_state == S_SR_CMP && $past(r_state) == S_SR_RD)
        |-> (r_idx < r_count))
        else $error("list read beyond count");

    a_no_emit_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result register overwritten while held");
`endif

endmodule
